@@ rtl/core/eaft_pkg.sv @@
// ----------------------------------------------------------------------------
// eaft_pkg
// Shared types, constants and helpers for the throttle arming and failsafe
// block and its iterative divider.
// ----------------------------------------------------------------------------
package eaft_pkg;

	// field widths
	localparam int PULSE_W = 11;
	localparam int SPEED_W = 16;
	localparam int COUNT_W = 16;
	localparam int DIVISOR_W = 15;
	localparam int MAG_W = 27;            // |speed| * |full - neutral| < 2**27
	localparam int SUM_W = MAG_W + 2;     // signed neutral plus signed quotient
	localparam int STEP_W = $clog2(MAG_W);

	// pulse limits in microseconds
	localparam logic [PULSE_W-1:0] PULSE_MIN_US = PULSE_W'(1000);
	localparam logic [PULSE_W-1:0] PULSE_MAX_US = PULSE_W'(2000);

	// register reset values
	localparam logic [PULSE_W-1:0] NEUTRAL_RST = PULSE_W'(1500);
	localparam logic [PULSE_W-1:0] FULL_RST = PULSE_W'(2000);
	localparam logic [COUNT_W-1:0] ARM_TIME_RST = COUNT_W'(3000);
	localparam logic [COUNT_W-1:0] TIMEOUT_RST = COUNT_W'(500);
	localparam logic [SPEED_W-1:0] PCT_LOW_RST = '0;
	localparam logic [DIVISOR_W-1:0] PCT_HIGH_RST = DIVISOR_W'(100);
	localparam logic [SPEED_W-1:0] SPEED_RST = SPEED_W'(1500);

	// input kinds carried on tuser
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_CMD = 1'b1;

	// configuration register map
	typedef enum logic [2:0] {
		REG_NEUTRAL  = 3'd0,
		REG_FULL     = 3'd1,
		REG_ARM_TIME = 3'd2,
		REG_TIMEOUT  = 3'd3,
		REG_PCT_LOW  = 3'd4,
		REG_PCT_HIGH = 3'd5
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV
	} seq_state_t;

	// divider request and response
	typedef struct packed {
		logic                 start;
		logic [MAG_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] quotient;
	} div_rsp_t;

	// saturate a signed pulse to the legal range
	function automatic logic [PULSE_W-1:0] clamp_pulse(input logic signed [SUM_W-1:0] p);
		logic [PULSE_W-1:0] r;
		if (p < $signed({{(SUM_W-PULSE_W){1'b0}}, PULSE_MIN_US}))
			r = PULSE_MIN_US;
		else if (p > $signed({{(SUM_W-PULSE_W){1'b0}}, PULSE_MAX_US}))
			r = PULSE_MAX_US;
		else
			r = p[PULSE_W-1:0];
		return r;
	endfunction

endpackage

@@ rtl/core/eaft_div.sv @@
// ----------------------------------------------------------------------------
// eaft_div
// Restoring unsigned divider, one quotient bit per cycle. A start pulse loads
// the dividend; done pulses for one cycle when the quotient is final.
// ----------------------------------------------------------------------------
module eaft_div (
	input  logic              clk,
	input  logic              arst_n,
	input  eaft_pkg::div_req_t req,
	output eaft_pkg::div_rsp_t rsp
);
	import eaft_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_W-1:0]    step_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [MAG_W-1:0]     quo_q;
	logic [DIVISOR_W:0]   partial;
	logic [DIVISOR_W:0]   trial;
	logic                 fits;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		partial = {rem_q, quo_q[MAG_W-1]};
		trial = partial - {1'b0, req.divisor};
		fits = partial >= {1'b0, req.divisor};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(MAG_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// datapath: remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ rtl/core/esc_arming_failsafe_throttle.sv @@
// ----------------------------------------------------------------------------
// esc_arming_failsafe_throttle
// Throttle pulse generator for a motor speed controller with arming delay,
// command timeout failsafe and obstacle override.
//
// Usage:
//   s_* stream takes one item per transfer: s_tuser selects a one
//   millisecond tick (0) or a speed command (1); s_tdata carries the speed
//   value and the drive mode and obstacle flags. Every input transfer gives
//   exactly one result transfer on m_*, carrying the saturated pulse width,
//   the enable, armed and link-lost flags and the stored speed.
//   Every item other than a tick that scales a percent speed finishes in
//   the accepting cycle: the result is valid in the next cycle. A tick that
//   scales a percent speed runs the multiply state, then the shared
//   one-bit-per-cycle divider, then loads the quotient result into the
//   output register. One item is in flight at a time. s_tready is high
//   only when the sequencer is idle and the output register is empty or
//   being drained, so a stalled m_tready holds the result and blocks new
//   input. Reset clears the output enable, armed flag and both timers,
//   sets the stored speed to 1500 us and loads the register defaults.
//   The APB registers must be written only while idle; the block itself
//   does not enforce it.
// ----------------------------------------------------------------------------
module esc_arming_failsafe_throttle (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // speed_value[15:0], drive_mode[16], obstacle_override[17]
	input  logic        s_tuser,   // action
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // pulse_us[10:0], output_enabled[11], is_armed[12],
	                               // link_lost[13], stored_speed[29:14]
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import eaft_pkg::*;

	// configuration registers
	logic [PULSE_W-1:0]   neutral_q;
	logic [PULSE_W-1:0]   full_q;
	logic [COUNT_W-1:0]   arm_time_q;
	logic [COUNT_W-1:0]   timeout_q;
	logic [SPEED_W-1:0]   pct_low_q;
	logic [DIVISOR_W-1:0] pct_high_q;
	cfg_reg_t             reg_sel;
	logic                 cfg_wr;

	// block state
	logic               att_q, armed_q;
	logic [COUNT_W-1:0] ae_q, ca_q;
	logic [SPEED_W-1:0] spd_q;

	// step logic
	logic               action, drive, obstacle;
	logic [SPEED_W-1:0] speed_in;
	logic               att_d, armed_d, armed_eff, lost_d, need_div, in_range;
	logic [COUNT_W-1:0] ae_inc, ca_inc, ae_d, ca_d;
	logic [SPEED_W-1:0] spd_d;
	logic [PULSE_W-1:0] pulse_d, neutral_clamped;
	logic               accept;

	// sequencer and shared divider
	seq_state_t state_q, state_d;
	div_req_t   div_req;
	div_rsp_t   div_rsp;
	logic       neg_q;
	logic signed [PULSE_W:0] diff;
	logic [SPEED_W-1:0]      s_mag;
	logic [PULSE_W-1:0]      d_mag;
	logic signed [SUM_W-1:0] q_signed, scaled;

	// output register
	logic               m_tvalid_q;
	logic [PULSE_W-1:0] out_pulse_q;
	logic               out_en_q, out_armed_q, out_lost_q;
	logic [SPEED_W-1:0] out_spd_q;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[4:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neutral_q  <= NEUTRAL_RST;
			full_q     <= FULL_RST;
			arm_time_q <= ARM_TIME_RST;
			timeout_q  <= TIMEOUT_RST;
			pct_low_q  <= PCT_LOW_RST;
			pct_high_q <= PCT_HIGH_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_NEUTRAL:  neutral_q  <= pwdata[PULSE_W-1:0];
				REG_FULL:     full_q     <= pwdata[PULSE_W-1:0];
				REG_ARM_TIME: arm_time_q <= pwdata[COUNT_W-1:0];
				REG_TIMEOUT:  timeout_q  <= pwdata[COUNT_W-1:0];
				REG_PCT_LOW:  pct_low_q  <= pwdata[SPEED_W-1:0];
				REG_PCT_HIGH: pct_high_q <= pwdata[DIVISOR_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_sel)
			REG_NEUTRAL:  prdata = {21'b0, neutral_q};
			REG_FULL:     prdata = {21'b0, full_q};
			REG_ARM_TIME: prdata = {16'b0, arm_time_q};
			REG_TIMEOUT:  prdata = {16'b0, timeout_q};
			REG_PCT_LOW:  prdata = {16'b0, pct_low_q};
			REG_PCT_HIGH: prdata = {17'b0, pct_high_q};
			default:      prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// step decode: tick timers, enable, arming and failsafe
	// ------------------------------------------------------------------
	assign action = s_tuser;
	assign speed_in = s_tdata[15:0];
	assign drive = s_tdata[16];
	assign obstacle = s_tdata[17];

	assign neutral_clamped = clamp_pulse($signed({{(SUM_W-PULSE_W){1'b0}}, neutral_q}));
	assign in_range = ($signed(spd_q) >= $signed(pct_low_q))
		&& ($signed(spd_q) <= $signed({1'b0, pct_high_q}));

	always_comb begin
		ae_inc = (ae_q == '1) ? ae_q : ae_q + 1'b1;
		ca_inc = (ca_q == '1) ? ca_q : ca_q + 1'b1;
		att_d = att_q;
		armed_d = armed_q;
		armed_eff = armed_q;
		ae_d = ae_q;
		ca_d = ca_q;
		spd_d = spd_q;
		lost_d = 1'b0;
		need_div = 1'b0;
		pulse_d = neutral_clamped;
		if (action == ACT_CMD) begin
			spd_d = speed_in;
			ca_d = '0;
		end else if (!drive) begin
			att_d = 1'b0;
			ae_d = ae_inc;
			ca_d = ca_inc;
		end else begin
			// entering drive mode restarts timers and disarms
			att_d = 1'b1;
			armed_eff = att_q && armed_q;
			armed_d = armed_eff;
			ae_d = att_q ? ae_inc : '0;
			ca_d = att_q ? ca_inc : '0;
			if (!armed_eff) begin
				if (ae_d >= arm_time_q)
					armed_d = 1'b1;
			end else if (ca_d >= timeout_q) begin
				lost_d = 1'b1;
			end else if (!obstacle) begin
				if (!in_range)
					pulse_d = clamp_pulse(SUM_W'($signed(spd_q)));
				else if (pct_high_q != '0)
					need_div = 1'b1;
			end
		end
	end

	assign accept = s_tvalid && s_tready;

	// state update on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q   <= 1'b0;
			armed_q <= 1'b0;
			ae_q    <= '0;
			ca_q    <= '0;
			spd_q   <= SPEED_RST;
		end else if (accept) begin
			att_q   <= att_d;
			armed_q <= armed_d;
			ae_q    <= ae_d;
			ca_q    <= ca_d;
			spd_q   <= spd_d;
		end
	end

	// ------------------------------------------------------------------
	// percent scaling sequencer: multiply, then shared divider
	// ------------------------------------------------------------------
	assign diff = $signed({1'b0, full_q}) - $signed({1'b0, neutral_q});
	assign s_mag = spd_q[SPEED_W-1] ? SPEED_W'(-spd_q) : spd_q;
	assign d_mag = diff[PULSE_W] ? PULSE_W'(-diff) : diff[PULSE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		div_req.start = 1'b0;
		div_req.dividend = MAG_W'(s_mag * d_mag);
		div_req.divisor = pct_high_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = !m_tvalid_q || m_tready;
				if (s_tvalid && s_tready && need_div)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				div_req.start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// quotient sign follows the operand signs
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL)
			neg_q <= spd_q[SPEED_W-1] ^ diff[PULSE_W];
	end

	eaft_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign q_signed = neg_q ? -$signed({2'b0, div_rsp.quotient})
		: $signed({2'b0, div_rsp.quotient});
	assign scaled = $signed({{(SUM_W-PULSE_W){1'b0}}, neutral_q}) + q_signed;

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if ((accept && !need_div) || (state_q == ST_DIV && div_rsp.done))
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_pulse_q <= pulse_d;
			out_en_q    <= att_d;
			out_armed_q <= armed_d;
			out_lost_q  <= lost_d;
			out_spd_q   <= spd_d;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			out_pulse_q <= clamp_pulse(scaled);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {2'b0, out_spd_q, out_lost_q, out_armed_q, out_en_q, out_pulse_q};

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// a new transfer never overwrites a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!m_tvalid_q || m_tready))
		else $error("input taken while result pending");

	// no input while a scaling is under way
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("ready while sequencer busy");

	// divider completes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider done outside wait state");

	// results always carry a saturated pulse
	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (out_pulse_q >= PULSE_MIN_US && out_pulse_q <= PULSE_MAX_US))
		else $error("pulse out of range");

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the throttle arming and failsafe block. A
// bit-accurate throttle predictor follows every accepted transfer on the
// input stream and queues the expected pulse result. Results are compared
// field by field as they leave the result stream. Stimulus runs through
// register settings from reset defaults to the extremes, covering directed
// arming and scaling cases, random drive sequences, a long command silence
// and receiver backpressure.
// ----------------------------------------------------------------------------
module tb;
	import eaft_pkg::*;

	localparam int unsigned STALL_LIMIT = 3000;   // quiet cycles before giving up
	localparam int unsigned HOLD_AFTER = 500;     // results before the long hold-off
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned COUNT_SAT = 65535;
	localparam int unsigned REPORT_CAP = 100;

	// one input item and one result item
	typedef struct {
		logic               action;
		logic signed [15:0] speed;
		logic               drive;
		logic               obstacle;
	} throttle_cmd_t;

	typedef struct {
		logic [10:0] pulse_us;
		logic        output_enabled;
		logic        is_armed;
		logic        link_lost;
		logic [15:0] stored_speed;
	} throttle_res_t;

	// register setting and traffic mix of one phase
	typedef struct {
		int neutral;
		int full;
		int arm;
		int timeout;
		int pct_lo;
		int pct_hi;
		int items;
		int cmd_pct;
	} phase_t;

	// throttle predictor with its queue of expected pulses
	class throttle_scoreboard;
		int unsigned neutral_us = 1500;
		int unsigned full_us = 2000;
		int unsigned arm_time = 3000;
		int unsigned cmd_timeout = 500;
		int pct_low = 0;
		int unsigned pct_high = 100;

		bit attached = 1'b0;
		bit armed = 1'b0;
		int unsigned arm_ms = 0;
		int unsigned cmd_age = 0;
		logic signed [15:0] speed_reg = 16'sd1500;

		throttle_res_t expected_pulses[$];
		int unsigned fails = 0;
		int unsigned results_seen = 0;

		function void set_reg(cfg_reg_t idx, logic [31:0] w);
			logic signed [15:0] lo;
			lo = w[15:0];
			case (idx)
				REG_NEUTRAL: neutral_us = w[10:0];
				REG_FULL: full_us = w[10:0];
				REG_ARM_TIME: arm_time = w[15:0];
				REG_TIMEOUT: cmd_timeout = w[15:0];
				REG_PCT_LOW: pct_low = lo;
				REG_PCT_HIGH: pct_high = w[14:0];
				default: ;
			endcase
		endfunction

		function int unsigned sat_us(longint p);
			if (p < longint'(PULSE_MIN_US))
				return PULSE_MIN_US;
			if (p > longint'(PULSE_MAX_US))
				return PULSE_MAX_US;
			return int'(p);
		endfunction

		function int unsigned bump(int unsigned c);
			return (c < COUNT_SAT) ? c + 1 : COUNT_SAT;
		endfunction

		// stored speed as a pulse: percent range scaled, anything else as is
		function longint speed_pulse();
			longint s;
			longint n;
			s = longint'(speed_reg);
			n = longint'(neutral_us);
			if (s >= longint'(pct_low) && s <= longint'(pct_high)) begin
				if (pct_high == 0)
					return n;
				return n + (s * (longint'(full_us) - n)) / longint'(pct_high);
			end
			return s;
		endfunction

		function throttle_res_t predict_pulse(throttle_cmd_t it);
			throttle_res_t r;
			int unsigned pulse;
			bit lost;
			pulse = sat_us(longint'(neutral_us));
			lost = 1'b0;
			if (it.action == ACT_CMD) begin
				speed_reg = it.speed;
				cmd_age = 0;
			end else begin
				arm_ms = bump(arm_ms);
				cmd_age = bump(cmd_age);
				if (!it.drive) begin
					attached = 1'b0;
				end else begin
					// entering drive mode restarts arming and the link timer
					if (!attached) begin
						attached = 1'b1;
						armed = 1'b0;
						arm_ms = 0;
						cmd_age = 0;
					end
					if (!armed) begin
						if (arm_ms >= arm_time)
							armed = 1'b1;
					end else if (cmd_age >= cmd_timeout) begin
						lost = 1'b1;
					end else if (!it.obstacle) begin
						pulse = sat_us(speed_pulse());
					end
				end
			end
			r.pulse_us = pulse[10:0];
			r.output_enabled = attached;
			r.is_armed = armed;
			r.link_lost = lost;
			r.stored_speed = speed_reg;
			return r;
		endfunction

		function void note_item(throttle_cmd_t it);
			expected_pulses.push_back(predict_pulse(it));
		endfunction

		function int unsigned waiting();
			return expected_pulses.size();
		endfunction

		// printing is capped so a broken block cannot flood the log
		function void flag(string field, logic [15:0] want, logic [15:0] got);
			fails++;
			if (fails <= REPORT_CAP)
				$error("%s: expected %0d, actual %0d", field, want, got);
		endfunction

		function void check_result(throttle_res_t got);
			throttle_res_t want;
			results_seen++;
			if (expected_pulses.size() == 0) begin
				fails++;
				if (fails <= REPORT_CAP)
					$error("result transfer with no expected pulse pending");
				return;
			end
			want = expected_pulses.pop_front();
			if (got.pulse_us !== want.pulse_us)
				flag("pulse_us", 16'(want.pulse_us), 16'(got.pulse_us));
			if (got.output_enabled !== want.output_enabled)
				flag("output_enabled", 16'(want.output_enabled), 16'(got.output_enabled));
			if (got.is_armed !== want.is_armed)
				flag("is_armed", 16'(want.is_armed), 16'(got.is_armed));
			if (got.link_lost !== want.link_lost)
				flag("link_lost", 16'(want.link_lost), 16'(got.link_lost));
			if (got.stored_speed !== want.stored_speed)
				flag("stored_speed", want.stored_speed, got.stored_speed);
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // speed_value[15:0], drive_mode[16], obstacle_override[17]
	logic        s_tuser = 1'b0; // action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // pulse_us[10:0], output_enabled[11], is_armed[12],
	                             // link_lost[13], stored_speed[29:14]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	throttle_scoreboard sb = new();

	esc_arming_failsafe_throttle dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic throttle_cmd_t tick_item(logic drive, logic obstacle);
		throttle_cmd_t it;
		it.action = ACT_TICK;
		it.speed = 16'($urandom);
		it.drive = drive;
		it.obstacle = obstacle;
		return it;
	endfunction

	function automatic throttle_cmd_t cmd_item(int speed);
		throttle_cmd_t it;
		it.action = ACT_CMD;
		it.speed = speed[15:0];
		it.drive = 1'($urandom);
		it.obstacle = 1'($urandom);
		return it;
	endfunction

	// random item: mostly drive-mode ticks, some commands, rare drive exits
	function automatic throttle_cmd_t pick_item(int unsigned cmd_pct);
		throttle_cmd_t it;
		int lo;
		int hi;
		int v;
		lo = sb.pct_low;
		hi = int'(sb.pct_high);
		if ($urandom_range(99) < cmd_pct) begin
			it.action = ACT_CMD;
			it.drive = 1'($urandom);
			it.obstacle = 1'($urandom);
		end else begin
			it.action = ACT_TICK;
			it.drive = ($urandom_range(24) != 0);
			it.obstacle = ($urandom_range(7) == 0);
		end
		case ($urandom_range(4))
			0, 1: v = (hi >= lo) ? lo + int'($urandom_range(hi - lo)) : int'($urandom);
			2: v = 800 + int'($urandom_range(1400));
			3: v = int'($urandom);
			default: begin
				case ($urandom_range(5))
					0: v = -32768;
					1: v = 32767;
					2: v = lo;
					3: v = hi;
					4: v = 0;
					default: v = -1;
				endcase
			end
		endcase
		it.speed = v[15:0];
		return it;
	endfunction

	// one apb write: setup cycle, then access cycle
	task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
		logic [31:0] mask;
		logic [31:0] wdata;
		if (idx == REG_NEUTRAL || idx == REG_FULL)
			mask = 32'h0000_07FF;
		else if (idx == REG_PCT_HIGH)
			mask = 32'h0000_7FFF;
		else
			mask = 32'h0000_FFFF;
		// unused upper bits carry noise
		wdata = ($urandom & ~mask) | (value & mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, wdata);
		@(posedge clk);
	endtask

	task automatic configure(phase_t p);
		write_reg(REG_NEUTRAL, p.neutral);
		write_reg(REG_FULL, p.full);
		write_reg(REG_ARM_TIME, p.arm);
		write_reg(REG_TIMEOUT, p.timeout);
		write_reg(REG_PCT_LOW, p.pct_lo);
		write_reg(REG_PCT_HIGH, p.pct_hi);
	endtask

	// wait until every expected pulse has been checked
	task automatic drain();
		do @(posedge clk); while (sb.waiting() != 0);
	endtask

	// send items in bursts with random gaps; steady sends back to back
	task automatic play(input throttle_cmd_t batch[$], input bit steady);
		int unsigned burst;
		int unsigned gap;
		burst = 0;
		foreach (batch[i]) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				if (!steady) begin
					gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 14);
					if ($urandom_range(150) == 0) begin
						s_tvalid <= 1'b0;
						drain();
					end else if (gap != 0) begin
						s_tvalid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
			end
			burst--;
			s_tvalid <= 1'b1;
			s_tuser <= batch[i].action;
			s_tdata <= {6'b0, batch[i].obstacle, batch[i].drive, batch[i].speed};
			do @(posedge clk); while (!s_tready);
			sb.note_item(batch[i]);
		end
		s_tvalid <= 1'b0;
	endtask

	// result side: check transfers and stall on a pattern of its own
	initial begin : result_sink
		throttle_res_t got;
		int unsigned window;
		int unsigned mode;
		int unsigned hold_left;
		bit held;
		window = 0;
		mode = 0;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.pulse_us = m_tdata[10:0];
				got.output_enabled = m_tdata[11];
				got.is_armed = m_tdata[12];
				got.link_lost = m_tdata[13];
				got.stored_speed = m_tdata[29:14];
				sb.check_result(got);
			end
			// one long hold-off so the block backs up into its input
			if (!held && sb.results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (window == 0) begin
					window = $urandom_range(8, 64);
					mode = $urandom_range(3);
				end
				window--;
				case (mode)
					0, 1: m_tready <= 1'b1;
					2: m_tready <= 1'($urandom);
					default: m_tready <= ($urandom_range(3) == 0);
				endcase
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("esc_arming_failsafe_throttle regression: fail");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		throttle_cmd_t batch[$];
		phase_t plan[$];
		phase_t p;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: disabled output, command extremes, unarmed neutral
		batch = {};
		batch.push_back(tick_item(1'b0, 1'b0));
		batch.push_back(cmd_item(32767));
		batch.push_back(cmd_item(-32768));
		batch.push_back(tick_item(1'b1, 1'b1));
		batch.push_back(tick_item(1'b1, 1'b0));
		batch.push_back(cmd_item(1500));
		batch.push_back(tick_item(1'b0, 1'b0));
		play(batch, 1'b0);
		drain();

		// zero arm time, truncating scale, pass-through, saturation, timeout
		configure('{1500, 1999, 0, 3, -100, 100, 0, 0});
		batch = {};
		batch.push_back(cmd_item(100));
		batch.push_back(tick_item(1'b1, 1'b0));
		batch.push_back(cmd_item(-100));
		batch.push_back(tick_item(1'b1, 1'b0));
		batch.push_back(cmd_item(-33));
		batch.push_back(tick_item(1'b1, 1'b0));
		batch.push_back(cmd_item(33));
		batch.push_back(tick_item(1'b1, 1'b0));
		batch.push_back(cmd_item(2500));
		batch.push_back(tick_item(1'b1, 1'b0));
		batch.push_back(cmd_item(101));
		batch.push_back(tick_item(1'b1, 1'b0));
		batch.push_back(cmd_item(-32768));
		batch.push_back(tick_item(1'b1, 1'b0));
		batch.push_back(tick_item(1'b1, 1'b1));
		batch.push_back(tick_item(1'b1, 1'b0));
		batch.push_back(tick_item(1'b0, 1'b0));
		batch.push_back(tick_item(1'b1, 1'b0));
		play(batch, 1'b0);

		// register settings: typical, full span, reversed with zero timeout,
		// out of range pulses, zero divisor, never armed, then random ones
		plan.push_back('{1500, 2000, 3, 20, 0, 100, 150, 15});
		plan.push_back('{1000, 2000, 10, 65535, -32768, 32767, 120, 15});
		plan.push_back('{2000, 1000, 0, 0, -50, 50, 80, 20});
		plan.push_back('{0, 2047, 5, 30, -1000, 1000, 150, 12});
		plan.push_back('{1500, 2000, 1, 15, 0, 0, 60, 15});
		plan.push_back('{1500, 2000, 2, 10, -5, 0, 40, 15});
		plan.push_back('{1200, 1800, 65535, 40, 32767, 1, 60, 15});
		repeat (4) begin
			p.neutral = $urandom_range(900, 2100);
			p.full = $urandom_range(900, 2100);
			p.arm = $urandom_range(0, 12);
			p.timeout = $urandom_range(1, 40);
			p.pct_lo = -int'($urandom_range(0, 300));
			p.pct_hi = $urandom_range(1, 400);
			p.items = 80;
			p.cmd_pct = $urandom_range(8, 25);
			plan.push_back(p);
		end

		foreach (plan[k]) begin
			drain();
			configure(plan[k]);
			batch = {};
			repeat (plan[k].items) batch.push_back(pick_item(plan[k].cmd_pct));
			play(batch, 1'b0);
		end

		// long command silence: link lost once the timeout passes and held there
		drain();
		configure('{1500, 2000, 0, 60, 0, 100, 0, 0});
		batch = {};
		batch.push_back(cmd_item(1700));
		repeat (100) batch.push_back(tick_item(1'b1, 1'b0));
		play(batch, 1'b1);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.fails == 0 && sb.waiting() == 0)
			$display("esc_arming_failsafe_throttle regression: pass");
		else
			$display("esc_arming_failsafe_throttle regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/eaft_pkg.sv
rtl/core/eaft_div.sv
rtl/core/esc_arming_failsafe_throttle.sv
dv/tb.sv
